// File: hw/rtl/tcd_pkg.sv
// Shared types and byte codes for the telnet command deframer.
`default_nettype none

package tcd_pkg;

  // Telnet protocol byte codes
  localparam logic [7:0] CodeIac  = 8'd255;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeSe   = 8'd240;
  localparam logic [7:0] CodeLf   = 8'd10;
  localparam logic [7:0] CodeNul  = 8'd0;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDropNull     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDropLineFeed = 2'd1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_PARAM = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [1:0] command;
    logic [7:0] sb_option;
  } result_t;

  typedef struct packed {
    logic drop_null;
    logic drop_line_feed;
  } filter_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcd_parse.sv
// Parser state machine: phase and subnegotiation option, one byte per cycle while item_valid_i is high.
`default_nettype none

module tcd_parse
  import tcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  wire logic [7:0]  byte_i,
  input  wire filter_cfg_t cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhIac   = 3'd1;
  localparam logic [2:0] PhDont  = 3'd2;
  localparam logic [2:0] PhDo    = 3'd3;
  localparam logic [2:0] PhWont  = 3'd4;
  localparam logic [2:0] PhWill  = 3'd5;
  localparam logic [2:0] PhSbOpt = 3'd6;
  localparam logic [2:0] PhSbPar = 3'd7;

  logic [2:0] phase_q, phase_d;
  logic [7:0] sb_opt_q, sb_opt_d;
  logic       emit;
  logic       filtered;

  assign filtered = (byte_i == CodeNul && cfg_i.drop_null) ||
                    (byte_i == CodeLf && cfg_i.drop_line_feed);

  always_comb begin
    phase_d   = phase_q;
    sb_opt_d  = sb_opt_q;
    emit      = 1'b0;
    res_o     = '{kind: KIND_DATA, data: byte_i, command: 2'd0, sb_option: 8'd0};
    unique case (phase_q)
      PhIdle: begin
        if (byte_i == CodeIac) begin
          phase_d = PhIac;
        end else begin
          emit = !filtered;
        end
      end
      PhIac: begin
        phase_d = PhIdle;
        priority case (byte_i)
          CodeIac:  emit = 1'b1;  // escaped 255, never filtered
          CodeDont: phase_d = PhDont;
          CodeDo:   phase_d = PhDo;
          CodeWont: phase_d = PhWont;
          CodeWill: phase_d = PhWill;
          CodeSb:   phase_d = PhSbOpt;
          default:  phase_d = PhIdle;
        endcase
      end
      PhSbOpt: begin
        sb_opt_d = byte_i;
        phase_d  = PhSbPar;
      end
      PhSbPar: begin
        emit            = 1'b1;
        res_o.sb_option = sb_opt_q;
        if (byte_i == CodeSe) begin
          phase_d    = PhIdle;
          res_o.kind = KIND_END;
          res_o.data = 8'd0;
        end else begin
          res_o.kind = KIND_PARAM;
        end
      end
      PhDont, PhDo, PhWont, PhWill: begin
        phase_d       = PhIdle;
        emit          = 1'b1;
        res_o.kind    = KIND_CMD;
        res_o.command = 2'(phase_q - PhDont);
      end
    endcase
  end

  assign res_valid_o = item_valid_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      sb_opt_q <= 8'd0;
    end else if (item_valid_i) begin
      phase_q  <= phase_d;
      sb_opt_q <= sb_opt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcd_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
`default_nettype none

module tcd_out_stage
  import tcd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held result transfers this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/telnet_command_deframer.sv
// Top level of the telnet receive-side command deframer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | rx_byte_i
//  out     | output    | out_valid_o/out_stall_i | out_kind_o, out_byte_o,
//          |           |                       | out_command_o, out_sb_option_o
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_stall_o is low; a byte's result, if it
// has one, is offered once the byte has passed the input register and then
// the result register. The parser phase and subnegotiation option advance
// as a byte leaves the input register, so while the output is not stalled
// the throughput is one byte per cycle with no bubbles.
// A stalled output holds the result register; the input register fills and
// then in_stall_o rises until the result transfers.
// Reset clears both filters, the parser phase and the stored option.
`default_nettype none

module telnet_command_deframer
  import tcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input byte channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [7:0]              out_byte_o,
  output logic [1:0]              out_command_o,
  output logic [7:0]              out_sb_option_o,
  // configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i
);

  filter_cfg_t cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_accept;
  logic        stage_ready;
  logic        item_fire;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // Filter registers; writes past the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgDropNull) begin
        cfg_q.drop_null <= cfg_data_i;
      end
      if (cfg_index_i == CfgDropLineFeed) begin
        cfg_q.drop_line_feed <= cfg_data_i;
      end
    end
  end

  // Input register: holds a byte while the result register is blocked
  assign in_stall_o = in_valid_q && !stage_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign item_fire  = in_valid_q && stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  tcd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_fire),
    .byte_i       (in_byte_q),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tcd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (stage_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign out_kind_o      = out_res.kind;
  assign out_byte_o      = out_res.data;
  assign out_command_o   = out_res.command;
  assign out_sb_option_o = out_res.sb_option;

endmodule

`default_nettype wire

// File: hw/rtl/tcd_checker.sv
// Port-level checks for the telnet command deframer, bound to the top level.
`default_nettype none

module tcd_checker
  import tcd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] out_kind_o,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] out_command_o,
  input wire logic [7:0] out_sb_option_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_kind_o) && $stable(out_byte_o) &&
      $stable(out_command_o) && $stable(out_sb_option_o))
    else $error("result changed while stalled");

  a_command_only_on_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_CMD |-> out_command_o == 2'd0)
    else $error("command field set on a non-command result");

  a_no_option_outside_sb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_DATA || out_kind_o == KIND_CMD)
      |-> out_sb_option_o == 8'd0)
    else $error("subnegotiation option set on data or command result");

  a_end_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_END |-> out_byte_o == 8'd0)
    else $error("subnegotiation end carries a byte");

endmodule

bind telnet_command_deframer tcd_checker u_tcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_kind_o      (out_kind_o),
  .out_byte_o      (out_byte_o),
  .out_command_o   (out_command_o),
  .out_sb_option_o (out_sb_option_o)
);

`default_nettype wire
